[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion shorthands, clocked on clk, reset by rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every edge outside reset.
`define PLB_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define PLB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PLB_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/plb_pkg.sv]
// ----------------------------------------------------------------------------
// plb_pkg
// Shared types and constants for the positional list buffer.
// ----------------------------------------------------------------------------
package plb_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int COUNT_W  = 5;
    localparam int POS_W    = 5;
    localparam int DATA_W   = 32;
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // action codes
    localparam logic [2:0] ACT_INS_FRONT = 3'd0;
    localparam logic [2:0] ACT_INS_BACK  = 3'd1;
    localparam logic [2:0] ACT_INS_AT    = 3'd2;
    localparam logic [2:0] ACT_DEL_FRONT = 3'd3;
    localparam logic [2:0] ACT_DEL_BACK  = 3'd4;
    localparam logic [2:0] ACT_DEL_AT    = 3'd5;
    localparam logic [2:0] ACT_DUMP      = 3'd6;

    // status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_EMPTY   = 2'd1;
    localparam logic [1:0] STAT_INVALID = 2'd2;
    localparam logic [1:0] STAT_FULL    = 2'd3;

    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_REMOVE,
        CMD_ROTATE
    } cell_op_t;

    // broadcast to every cell; each cell compares idx with its own slot
    typedef struct packed {
        cell_op_t           op;
        logic [IDX_W-1:0]   idx;
        logic [DATA_W-1:0]  value;
    } cell_cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } state_t;

endpackage

[rtl/core/plb_cell.sv]
// ----------------------------------------------------------------------------
// plb_cell
// One slot of the shift array: holds, loads, or takes a neighbor's or the head value.
// ----------------------------------------------------------------------------
module plb_cell (
    input  logic                        clk,
    input  logic [plb_pkg::IDX_W-1:0]   slot,
    input  plb_pkg::cell_cmd_t          cmd,
    input  logic [plb_pkg::DATA_W-1:0]  left_val,
    input  logic [plb_pkg::DATA_W-1:0]  right_val,
    input  logic [plb_pkg::DATA_W-1:0]  head_val,
    output logic [plb_pkg::DATA_W-1:0]  val
);
    import plb_pkg::*;

    logic [DATA_W-1:0] val_reg;
    logic [DATA_W-1:0] val_next;

    always_comb
    begin
        val_next = val_reg;
        case (cmd.op)
            CMD_INSERT:
            begin
                if (slot > cmd.idx)
                    val_next = left_val;
                else if (slot == cmd.idx)
                    val_next = cmd.value;
            end
            CMD_REMOVE:
            begin
                if (slot >= cmd.idx)
                    val_next = right_val;
            end
            CMD_ROTATE:
            begin
                // the head value wraps around into the last occupied slot
                if (slot < cmd.idx)
                    val_next = right_val;
                else if (slot == cmd.idx)
                    val_next = head_val;
            end
            default:
            begin
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

[rtl/core/plb_ctrl.sv]
// ----------------------------------------------------------------------------
// plb_ctrl
// Action decode, occupancy tracking, dump sequencer and result registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module plb_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [2:0]                  action,
    input  logic [plb_pkg::DATA_W-1:0]  value,
    input  logic [plb_pkg::POS_W-1:0]   position,
    input  logic [plb_pkg::DATA_W-1:0]  head_val,
    output plb_pkg::cell_cmd_t          cmd,
    output logic                        busy,
    output logic                        strobe,
    output logic [1:0]                  status,
    output logic [plb_pkg::COUNT_W-1:0] entry_count,
    output logic [plb_pkg::DATA_W-1:0]  element,
    output logic                        final_item
);
    import plb_pkg::*;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     occ_reg, occ_next;
    logic [IDX_W-1:0]     dump_idx_reg, dump_idx_next;
    logic                 strobe_reg, strobe_next;
    logic [1:0]           status_reg, status_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [DATA_W-1:0]    element_reg, element_next;
    logic                 final_reg, final_next;

    logic [CMP_W-1:0]     occ_wide;
    logic [CMP_W-1:0]     pos_wide;
    logic [CMP_W-1:0]     occ_next_wide;
    logic [IDX_W-1:0]     last_idx;
    logic                 full;
    logic                 empty;

    assign occ_wide      = CMP_W'(occ_reg);
    assign pos_wide      = CMP_W'(position);
    assign occ_next_wide = CMP_W'(occ_next);
    assign last_idx      = IDX_W'(occ_reg - CNT_W'(1));
    assign full          = (occ_reg == CNT_W'(CAPACITY));
    assign empty         = (occ_reg == '0);

    always_comb
    begin
        state_next    = state_reg;
        occ_next      = occ_reg;
        dump_idx_next = dump_idx_reg;
        strobe_next   = 1'b0;
        status_next   = STAT_OK;
        element_next  = '0;
        final_next    = 1'b1;
        cmd.op        = CMD_HOLD;
        cmd.idx       = '0;
        cmd.value     = value;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    strobe_next = 1'b1;
                    unique case (action)
                        ACT_INS_FRONT:
                        begin
                            if (full)
                                status_next = STAT_FULL;
                            else
                            begin
                                cmd.op   = CMD_INSERT;
                                occ_next = occ_reg + CNT_W'(1);
                            end
                        end
                        ACT_INS_BACK:
                        begin
                            if (full)
                                status_next = STAT_FULL;
                            else
                            begin
                                cmd.op   = CMD_INSERT;
                                cmd.idx  = IDX_W'(occ_reg);
                                occ_next = occ_reg + CNT_W'(1);
                            end
                        end
                        ACT_INS_AT:
                        begin
                            if (pos_wide == '0 || pos_wide > occ_wide + CMP_W'(1))
                                status_next = STAT_INVALID;
                            else if (full)
                                status_next = STAT_FULL;
                            else
                            begin
                                cmd.op   = CMD_INSERT;
                                cmd.idx  = IDX_W'(pos_wide - CMP_W'(1));
                                occ_next = occ_reg + CNT_W'(1);
                            end
                        end
                        ACT_DEL_FRONT:
                        begin
                            if (empty)
                                status_next = STAT_EMPTY;
                            else
                            begin
                                cmd.op   = CMD_REMOVE;
                                occ_next = occ_reg - CNT_W'(1);
                            end
                        end
                        ACT_DEL_BACK:
                        begin
                            if (empty)
                                status_next = STAT_EMPTY;
                            else
                            begin
                                cmd.op   = CMD_REMOVE;
                                cmd.idx  = last_idx;
                                occ_next = occ_reg - CNT_W'(1);
                            end
                        end
                        ACT_DEL_AT:
                        begin
                            if (pos_wide == '0 || pos_wide > occ_wide)
                                status_next = STAT_INVALID;
                            else
                            begin
                                cmd.op   = CMD_REMOVE;
                                cmd.idx  = IDX_W'(pos_wide - CMP_W'(1));
                                occ_next = occ_reg - CNT_W'(1);
                            end
                        end
                        ACT_DUMP:
                        begin
                            if (empty)
                                status_next = STAT_EMPTY;
                            else
                            begin
                                strobe_next   = 1'b0;
                                state_next    = ST_DUMP;
                                dump_idx_next = '0;
                            end
                        end
                        default:
                        begin
                            status_next = STAT_INVALID;
                        end
                    endcase
                end
            end
            ST_DUMP:
            begin
                // head goes out, ring of occupied slots turns by one
                strobe_next  = 1'b1;
                element_next = head_val;
                cmd.op       = CMD_ROTATE;
                cmd.idx      = last_idx;
                final_next   = (dump_idx_reg == last_idx);
                if (dump_idx_reg == last_idx)
                    state_next = ST_IDLE;
                else
                    dump_idx_next = dump_idx_reg + IDX_W'(1);
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        count_next = occ_next_wide[COUNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            occ_reg      <= '0;
            dump_idx_reg <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            occ_reg      <= occ_next;
            dump_idx_reg <= dump_idx_next;
            strobe_reg   <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        count_reg   <= count_next;
        element_reg <= element_next;
        final_reg   <= final_next;
    end

    assign busy        = (state_reg == ST_DUMP);
    assign strobe      = strobe_reg;
    assign status      = status_reg;
    assign entry_count = count_reg;
    assign element     = element_reg;
    assign final_item  = final_reg;

    `PLB_ASSERT(a_occ_bound, occ_reg <= CNT_W'(CAPACITY), "occupancy above capacity")
    `PLB_ASSERT_IMP(a_dump_nonempty, busy, !empty, "dump running on an empty list")
    `PLB_ASSERT_NXT(a_update_result, start && !busy && action != ACT_DUMP,
        strobe && final_item, "update without its single result")
    `PLB_ASSERT_NXT(a_dump_end, busy && dump_idx_reg == last_idx,
        strobe && final_item && !busy, "dump did not end on its last element")
    `PLB_ASSERT_IMP(a_full_status, strobe && status == STAT_FULL,
        occ_reg == CNT_W'(CAPACITY), "full status while list not full")

endmodule

[rtl/core/positional_list_buffer_core.sv]
// ----------------------------------------------------------------------------
// positional_list_buffer_core
// Ordered list of signed 32-bit values held in a chain of shift cells.
// ----------------------------------------------------------------------------
// An item is taken on a rising edge with start high and busy low. Inserts and
// deletes (front, back, or 1-based position) can be issued back to back:
// every cell decides in parallel whether to hold, load the new value, or
// take its left or right neighbor. Each update returns one result on the
// cycle after it is taken: strobe high for one cycle, with status, the new
// entry_count and final_item set. A dump of N elements holds busy high while
// it runs and returns N results in list order, one per cycle, starting the
// cycle after busy rises; final_item marks the last. Dumping turns the
// occupied cells as a ring, one slot per cycle, and the head cell is read
// out, so once every element is out the list is back in place. An empty
// dump returns one result with status empty. The receiver cannot stall:
// results must be captured on the strobe cycle. No clearing pass is needed
// after reset.
// ----------------------------------------------------------------------------
module positional_list_buffer_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [2:0]                  action,
    input  logic signed [31:0]          value,
    input  logic [4:0]                  position,
    output logic                        strobe,
    output logic [1:0]                  status,
    output logic [4:0]                  entry_count,
    output logic signed [31:0]          element,
    output logic                        final_item
);
    import plb_pkg::*;

    // cell contents, slot 0 is the list front
    logic [DATA_W-1:0] cell_val [CAPACITY];
    cell_cmd_t         cmd;
    logic [DATA_W-1:0] element_raw;

    plb_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .action      (action),
        .value       (DATA_W'(value)),
        .position    (position),
        .head_val    (cell_val[0]),
        .cmd         (cmd),
        .busy        (busy),
        .strobe      (strobe),
        .status      (status),
        .entry_count (entry_count),
        .element     (element_raw),
        .final_item  (final_item)
    );

    assign element = signed'(element_raw);

    // Chain of cells. End cells feed back their own value where a neighbor
    // is missing; those inputs are never selected for a slot in use.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [DATA_W-1:0] left_in;
        logic [DATA_W-1:0] right_in;

        if (g == 0)
        begin : g_first
            assign left_in = cell_val[g];
        end
        else
        begin : g_mid_l
            assign left_in = cell_val[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_in = cell_val[g];
        end
        else
        begin : g_mid_r
            assign right_in = cell_val[g+1];
        end

        plb_cell u_cell (
            .clk       (clk),
            .slot      (IDX_W'(g)),
            .cmd       (cmd),
            .left_val  (left_in),
            .right_val (right_in),
            .head_val  (cell_val[0]),
            .val       (cell_val[g])
        );
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for positional_list_buffer_core.
// ----------------------------------------------------------------------------
// Items go in on the start/busy handshake. Every accepted item is run through
// a local list predictor. Its results are queued, and each strobe is
// compared field by field against the head of that queue. The run has two
// parts. A short directed table comes first: the empty and full corners, bad
// positions, the unused action code and dumps. A random part follows. It
// drifts the list between empty and full, and the sender's idle rate changes
// from one phase to the next.
// ----------------------------------------------------------------------------
module testbench;
    import plb_pkg::*;

    localparam logic [2:0] ACT_UNUSED  = 3'd7;   // no action behind this code
    localparam int         RAND_ITEMS  = 325;
    localparam int         PHASE_LEN   = 90;     // items per idling phase
    localparam int         DRIFT_LEN   = 30;     // items per grow/shrink stretch
    localparam int         DRAIN_WAIT  = 20;     // cycles after the last result
    localparam int         CYCLE_LIMIT = 200000;

    typedef struct {
        logic [1:0]         status;
        logic [4:0]         count;
        logic signed [31:0] element;
        logic               last;
    } list_result_t;

    // One directed row. reps repeats it. Where chk is set, the single result
    // is typed in here and replaces the predicted one.
    typedef struct {
        logic [2:0]         act;
        logic signed [31:0] val;
        logic [4:0]         pos;
        int                 reps;
        bit                 chk;
        logic [1:0]         t_status;
        logic [4:0]         t_count;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         action;
    logic signed [31:0] value;
    logic [4:0]         position;
    logic               strobe;
    logic [1:0]         status;
    logic [4:0]         entry_count;
    logic signed [31:0] element;
    logic               final_item;

    logic signed [31:0] list_vals [$];         // predicted list, front first
    list_result_t       results_pending [$];   // results owed by the block
    int                 mismatch_count = 0;
    int                 cycle_cnt      = 0;
    int                 idle_pct       = 0;    // sender idle chance, percent
    bit                 growing        = 1'b1; // random part: bias toward inserts

    stim_row_t dir_rows [22] = '{
        // empty list corners
        '{ACT_DEL_FRONT, 32'sd0,           5'd0,  1,  1'b1, STAT_EMPTY,   5'd0},
        '{ACT_DEL_BACK,  32'sd0,           5'd31, 1,  1'b1, STAT_EMPTY,   5'd0},
        '{ACT_DEL_AT,    32'sd0,           5'd1,  1,  1'b1, STAT_INVALID, 5'd0},
        '{ACT_DUMP,      32'sd0,           5'd0,  1,  1'b1, STAT_EMPTY,   5'd0},
        '{ACT_INS_AT,    32'sd5,           5'd0,  1,  1'b1, STAT_INVALID, 5'd0},
        '{ACT_INS_AT,    32'sd5,           5'd2,  1,  1'b1, STAT_INVALID, 5'd0},
        '{ACT_UNUSED,    32'sd9,           5'd1,  1,  1'b1, STAT_INVALID, 5'd0},
        // value extremes, insert at the tail position
        '{ACT_INS_FRONT, 32'sh7fffffff,    5'd0,  1,  1'b1, STAT_OK,      5'd1},
        '{ACT_INS_BACK,  32'sh80000000,    5'd0,  1,  1'b1, STAT_OK,      5'd2},
        '{ACT_INS_AT,    -32'sd1,          5'd2,  1,  1'b1, STAT_OK,      5'd3},
        '{ACT_INS_AT,    32'sd0,           5'd4,  1,  1'b1, STAT_OK,      5'd4},
        '{ACT_INS_AT,    32'sd7,           5'd31, 1,  1'b1, STAT_INVALID, 5'd4},
        '{ACT_DEL_AT,    32'sd0,           5'd0,  1,  1'b1, STAT_INVALID, 5'd4},
        '{ACT_DEL_AT,    32'sd0,           5'd5,  1,  1'b1, STAT_INVALID, 5'd4},
        '{ACT_DUMP,      32'sd0,           5'd0,  1,  1'b0, STAT_OK,      5'd0},
        '{ACT_DEL_AT,    32'sd0,           5'd2,  1,  1'b1, STAT_OK,      5'd3},
        '{ACT_DEL_FRONT, 32'sd0,           5'd0,  1,  1'b1, STAT_OK,      5'd2},
        // fill to capacity, then the full-list cases
        '{ACT_INS_BACK,  32'sh55555555,    5'd0,  14, 1'b0, STAT_OK,      5'd0},
        '{ACT_INS_FRONT, 32'sd1,           5'd0,  1,  1'b1, STAT_FULL,    5'd16},
        // bad position wins over full; the tail position reports full
        '{ACT_INS_AT,    32'sd1,           5'd31, 1,  1'b1, STAT_INVALID, 5'd16},
        '{ACT_INS_AT,    32'sd1,           5'd17, 1,  1'b1, STAT_FULL,    5'd16},
        '{ACT_DUMP,      32'sd0,           5'd0,  1,  1'b0, STAT_OK,      5'd0}
    };

    positional_list_buffer_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .value       (value),
        .position    (position),
        .strobe      (strobe),
        .status      (status),
        .entry_count (entry_count),
        .element     (element),
        .final_item  (final_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Predict the results of one action and update the local list.
    function automatic void predict_list(input logic [2:0] act,
                                         input logic signed [31:0] val,
                                         input logic [4:0] pos,
                                         output list_result_t res_q [$]);
        int         occ;
        logic [1:0] st;
        res_q = {};
        occ   = list_vals.size();
        st    = STAT_OK;
        case (act)
            ACT_INS_FRONT:
                if (occ >= CAPACITY) st = STAT_FULL;
                else list_vals.push_front(val);
            ACT_INS_BACK:
                if (occ >= CAPACITY) st = STAT_FULL;
                else list_vals.push_back(val);
            ACT_INS_AT:
                // position range is checked before the full check
                if (pos < 1 || pos > occ + 1) st = STAT_INVALID;
                else if (occ >= CAPACITY) st = STAT_FULL;
                else list_vals.insert(pos - 1, val);
            ACT_DEL_FRONT:
                if (occ == 0) st = STAT_EMPTY;
                else void'(list_vals.pop_front());
            ACT_DEL_BACK:
                if (occ == 0) st = STAT_EMPTY;
                else void'(list_vals.pop_back());
            ACT_DEL_AT:
                if (pos < 1 || pos > occ) st = STAT_INVALID;
                else list_vals.delete(pos - 1);
            ACT_DUMP:
                if (occ == 0) st = STAT_EMPTY;
                else
                begin
                    for (int i = 0; i < occ; i++)
                        res_q.push_back('{STAT_OK, 5'(occ), list_vals[i], i == occ - 1});
                    return;
                end
            default:
                st = STAT_INVALID;
        endcase
        res_q.push_back('{st, 5'(list_vals.size()), 32'sd0, 1'b1});
    endfunction

    // Random item, mostly well-formed for the current list length.
    task automatic pick_item(output logic [2:0] act,
                             output logic signed [31:0] val,
                             output logic [4:0] pos);
        int occ;
        int r;
        occ = list_vals.size();
        r   = $urandom_range(99);
        if (r < 3)
            act = ACT_UNUSED;
        else if (r < 15)
            act = ACT_DUMP;
        else if ((r < 65) == growing)
            act = 3'($urandom_range(ACT_INS_AT));      // one of the inserts
        else
            act = 3'($urandom_range(ACT_DEL_AT, ACT_DEL_FRONT));
        case ($urandom_range(9))
            0:       val = 32'sh80000000;
            1:       val = 32'sh7fffffff;
            2:       val = -32'sd1;
            default: val = $urandom;
        endcase
        if ($urandom_range(99) < 15)
            pos = 5'($urandom_range(31));
        else if (act == ACT_INS_AT)
            pos = 5'($urandom_range(occ + 1, 1));
        else
            pos = 5'($urandom_range(occ > 0 ? occ : 1, 1));
    endtask

    // Hand one item over: optional idle gap, then hold start until taken.
    task automatic send_item(input logic [2:0] act, input logic signed [31:0] val,
                             input logic [4:0] pos, input bit chk,
                             input logic [1:0] t_status, input logic [4:0] t_count);
        list_result_t fresh [$];
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        start    <= 1'b1;
        action   <= act;
        value    <= val;
        position <= pos;
        do @(posedge clk); while (busy);
        // taken at this edge; an update's result comes at the next one
        predict_list(act, val, pos, fresh);
        if (chk)
            results_pending.push_back('{t_status, t_count, 32'sd0, 1'b1});
        else
            foreach (fresh[i]) results_pending.push_back(fresh[i]);
    endtask

    // Result checker: the receiver cannot stall, so every strobe is taken.
    always @(posedge clk)
    begin
        list_result_t exp_res;
        if (rst_n && strobe)
        begin
            if (results_pending.size() == 0)
            begin
                mismatch_count++;
                $display("%0t unexpected result: status=%0d count=%0d element=%0d final=%0b",
                         $realtime, status, entry_count, element, final_item);
            end
            else
            begin
                exp_res = results_pending.pop_front();
                if (exp_res.status !== status || exp_res.count !== entry_count ||
                    exp_res.element !== element || exp_res.last !== final_item)
                begin
                    mismatch_count++;
                    $display("%0t mismatch: expected status=%0d count=%0d element=%0d final=%0b",
                             $realtime, exp_res.status, exp_res.count, exp_res.element,
                             exp_res.last);
                    $display("%0t           actual   status=%0d count=%0d element=%0d final=%0b",
                             $realtime, status, entry_count, element, final_item);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        logic [2:0]         r_act;
        logic signed [31:0] r_val;
        logic [4:0]         r_pos;
        rst_n    = 1'b0;
        start    = 1'b0;
        action   = ACT_INS_FRONT;
        value    = 32'sd0;
        position = 5'd0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed table, no idling
        foreach (dir_rows[k])
            repeat (dir_rows[k].reps)
                send_item(dir_rows[k].act, dir_rows[k].val, dir_rows[k].pos,
                          dir_rows[k].chk, dir_rows[k].t_status, dir_rows[k].t_count);

        // random part: idling phases of none, heavy, light, none
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            case (n / PHASE_LEN)
                0:       idle_pct = 0;
                1:       idle_pct = 58;
                2:       idle_pct = 13;
                default: idle_pct = 0;
            endcase
            growing = ((n / DRIFT_LEN) % 2) == 0;
            pick_item(r_act, r_val, r_pos);
            send_item(r_act, r_val, r_pos, 1'b0, STAT_OK, 5'd0);
        end
        start <= 1'b0;

        while (results_pending.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
